[sv/kwl_pkg.sv]
// shared types, codes and keyword tables for the keyword token lexer
`default_nettype none

package kwl_pkg;

  // default parameter values
  localparam int unsigned MaxLexemeDef = 19;
  localparam int unsigned LineBitsDef  = 16;

  // fixed field widths
  localparam int unsigned CodeW = 5;
  localparam int unsigned TLineW = 16;
  localparam int unsigned TLenW = 5;
  localparam int unsigned KwCount = 9;

  // scan modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_WORD  = 3'd1;
  localparam logic [2:0] MODE_NUM   = 3'd2;
  localparam logic [2:0] MODE_EQ    = 3'd3;
  localparam logic [2:0] MODE_COLON = 3'd4;
  localparam logic [2:0] MODE_LT    = 3'd5;
  localparam logic [2:0] MODE_GT    = 3'd6;

  // token codes
  localparam logic [CodeW-1:0] TK_ID     = 5'd0;
  localparam logic [CodeW-1:0] TK_NUM    = 5'd10;
  localparam logic [CodeW-1:0] TK_SEMI   = 5'd11;
  localparam logic [CodeW-1:0] TK_DOT    = 5'd12;
  localparam logic [CodeW-1:0] TK_PLUS   = 5'd13;
  localparam logic [CodeW-1:0] TK_MINUS  = 5'd14;
  localparam logic [CodeW-1:0] TK_STAR   = 5'd15;
  localparam logic [CodeW-1:0] TK_SLASH  = 5'd16;
  localparam logic [CodeW-1:0] TK_COMMA  = 5'd17;
  localparam logic [CodeW-1:0] TK_EQEQ   = 5'd18;
  localparam logic [CodeW-1:0] TK_ASSIGN = 5'd19;
  localparam logic [CodeW-1:0] TK_LT     = 5'd20;
  localparam logic [CodeW-1:0] TK_LE     = 5'd21;
  localparam logic [CodeW-1:0] TK_GT     = 5'd22;
  localparam logic [CodeW-1:0] TK_GE     = 5'd23;
  localparam logic [CodeW-1:0] TK_LPAREN = 5'd24;
  localparam logic [CodeW-1:0] TK_RPAREN = 5'd25;
  localparam logic [CodeW-1:0] TK_END    = 5'd26;
  localparam logic [CodeW-1:0] TK_ERR    = 5'd27;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;

  // keyword spellings, padded with zeros; keyword k has token code k+1
  localparam logic [7:0] KW_TEXT [KwCount][8] = '{
    '{"p", "r", "o", "g", "r", "a", "m", 8'h00},
    '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"B", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "r", "i", "t", "e", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] KW_LEN [KwCount] = '{4'd7, 4'd5, 4'd3, 4'd5, 4'd4, 4'd5, 4'd2,
                                              4'd3, 4'd5};

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [TLineW-1:0] line;
    logic [TLenW-1:0]  len;
    logic              too_long;
    logic              last;
  } tok_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

endpackage

`default_nettype wire

[sv/kwl_char_if.sv]
// valid/ready channel carrying one source character item
`default_nettype none

interface kwl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink   (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

[sv/kwl_token_if.sv]
// valid/ready channel carrying one token item
`default_nettype none

interface kwl_token_if;
  logic                      valid;
  logic                      ready;
  logic [kwl_pkg::CodeW-1:0]  token_code;
  logic [kwl_pkg::TLineW-1:0] token_line;
  logic [kwl_pkg::TLenW-1:0]  lexeme_length;
  logic                      too_long;
  logic                      last_of_run;

  modport source (output valid, output token_code, output token_line, output lexeme_length,
                  output too_long, output last_of_run, input ready);
  modport sink   (input valid, input token_code, input token_line, input lexeme_length,
                  input too_long, input last_of_run, output ready);
endinterface

`default_nettype wire

[sv/kwl_scan.sv]
// next-state and token logic for one character of the lexer
`default_nettype none

module kwl_scan #(
  parameter int unsigned MaxLexeme = kwl_pkg::MaxLexemeDef,
  parameter int unsigned LineBits  = kwl_pkg::LineBitsDef,
  localparam int unsigned LenW     = $clog2(MaxLexeme + 1)
) (
  input  wire logic [7:0]                  char_i,
  input  wire logic                        end_i,
  input  wire logic [2:0]                  mode_i,
  input  wire logic [LineBits-1:0]         line_i,
  input  wire logic [LineBits-1:0]         start_i,
  input  wire logic [LenW-1:0]             len_i,
  input  wire logic [kwl_pkg::KwCount-1:0] alive_i,
  input  wire logic                        ovf_i,
  input  wire logic                        fin_i,
  output logic      [2:0]                  mode_o,
  output logic      [LineBits-1:0]         line_o,
  output logic      [LineBits-1:0]         start_o,
  output logic      [LenW-1:0]             len_o,
  output logic      [kwl_pkg::KwCount-1:0] alive_o,
  output logic                             ovf_o,
  output logic                             fin_o,
  output kwl_pkg::tok_t                    tok_o [2],
  output logic      [1:0]                  cnt_o
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxLexeme);

  // fixed-width views of the running line and length
  logic [LineBits+kwl_pkg::TLineW-1:0] line_ext, start_ext;
  logic [LenW+kwl_pkg::TLenW-1:0]      len_ext;
  logic [kwl_pkg::TLineW-1:0]          line16, start16;
  logic [kwl_pkg::TLenW-1:0]           len5;

  assign line_ext  = {{kwl_pkg::TLineW{1'b0}}, line_i};
  assign start_ext = {{kwl_pkg::TLineW{1'b0}}, start_i};
  assign len_ext   = {{kwl_pkg::TLenW{1'b0}}, len_i};
  assign line16    = line_ext[kwl_pkg::TLineW-1:0];
  assign start16   = start_ext[kwl_pkg::TLineW-1:0];
  assign len5      = len_ext[kwl_pkg::TLenW-1:0];

  // token for the lexeme in progress, emitted when it ends
  kwl_pkg::tok_t flush_tok;
  logic          flush_vld;
  logic [kwl_pkg::CodeW-1:0] word_code;

  always_comb begin
    word_code = kwl_pkg::TK_ID;
    for (int k = 0; k < kwl_pkg::KwCount; k++) begin
      if (alive_i[k] && (len_ext == (LenW + kwl_pkg::TLenW)'(kwl_pkg::KW_LEN[k]))) begin
        word_code = kwl_pkg::CodeW'(k + 1);
      end
    end
  end

  always_comb begin
    flush_tok = '{code: kwl_pkg::TK_ERR, line: start16, len: kwl_pkg::TLenW'(1),
                  too_long: 1'b0, last: 1'b0};
    flush_vld = 1'b1;
    unique case (mode_i)
      kwl_pkg::MODE_WORD: begin
        flush_tok.code     = word_code;
        flush_tok.len      = len5;
        flush_tok.too_long = ovf_i;
      end
      kwl_pkg::MODE_NUM: begin
        flush_tok.code     = kwl_pkg::TK_NUM;
        flush_tok.len      = len5;
        flush_tok.too_long = ovf_i;
      end
      kwl_pkg::MODE_EQ:    flush_tok.code = kwl_pkg::TK_ASSIGN;
      kwl_pkg::MODE_COLON: flush_tok.code = kwl_pkg::TK_ERR;
      kwl_pkg::MODE_LT:    flush_tok.code = kwl_pkg::TK_LT;
      kwl_pkg::MODE_GT:    flush_tok.code = kwl_pkg::TK_GT;
      default:             flush_vld = 1'b0;
    endcase
  end

  always_comb begin
    logic                        done;
    logic                        add_c;
    logic [LenW-1:0]             base_len;
    logic [kwl_pkg::KwCount-1:0] base_alive;
    logic                        base_word;
    logic [1:0]                  n;
    kwl_pkg::tok_t               single;
    logic                        single_vld;

    mode_o     = mode_i;
    line_o     = line_i;
    start_o    = start_i;
    len_o      = len_i;
    alive_o    = alive_i;
    ovf_o      = ovf_i;
    fin_o      = fin_i;
    tok_o[0]   = '0;
    tok_o[1]   = '0;
    n          = 2'd0;
    done       = 1'b0;
    add_c      = 1'b0;
    base_len   = len_i;
    base_alive = alive_i;
    base_word  = (mode_i == kwl_pkg::MODE_WORD);
    single     = '{code: kwl_pkg::TK_ERR, line: line16, len: kwl_pkg::TLenW'(1),
                   too_long: 1'b0, last: 1'b0};
    single_vld = 1'b0;

    if (fin_i) begin
      // nothing more until reset
    end else if (end_i) begin
      if (flush_vld) begin
        tok_o[n[0]] = flush_tok;
        n = n + 2'd1;
      end
      tok_o[n[0]] = '{code: kwl_pkg::TK_END, line: line16, len: '0, too_long: 1'b0,
                      last: 1'b0};
      n      = n + 2'd1;
      fin_o  = 1'b1;
      mode_o = kwl_pkg::MODE_IDLE;
    end else begin
      unique case (mode_i)
        kwl_pkg::MODE_WORD: begin
          if (kwl_pkg::is_alpha(char_i) || kwl_pkg::is_digit(char_i)) begin
            add_c = 1'b1;
            done  = 1'b1;
          end
        end
        kwl_pkg::MODE_NUM: begin
          if (kwl_pkg::is_digit(char_i)) begin
            add_c = 1'b1;
            done  = 1'b1;
          end
        end
        kwl_pkg::MODE_EQ, kwl_pkg::MODE_COLON, kwl_pkg::MODE_LT, kwl_pkg::MODE_GT: begin
          if (char_i == kwl_pkg::CH_EQ) begin
            // two-character operator completes here
            tok_o[0] = '{code: kwl_pkg::TK_EQEQ, line: start16, len: kwl_pkg::TLenW'(2),
                         too_long: 1'b0, last: 1'b0};
            unique case (mode_i)
              kwl_pkg::MODE_COLON: tok_o[0].code = kwl_pkg::TK_ASSIGN;
              kwl_pkg::MODE_LT:    tok_o[0].code = kwl_pkg::TK_LE;
              kwl_pkg::MODE_GT:    tok_o[0].code = kwl_pkg::TK_GE;
              default:             tok_o[0].code = kwl_pkg::TK_EQEQ;
            endcase
            n    = 2'd1;
            done = 1'b1;
          end
        end
        default: ;
      endcase

      if (!done || (mode_i != kwl_pkg::MODE_WORD && mode_i != kwl_pkg::MODE_NUM)) begin
        mode_o = kwl_pkg::MODE_IDLE;
      end

      if (!done) begin
        if (flush_vld) begin
          tok_o[0] = flush_tok;
          n = 2'd1;
        end
        // start of a new lexeme or a one-character token
        if (char_i == kwl_pkg::CH_LF) begin
          line_o = line_i + LineBits'(1);
        end else if (char_i == kwl_pkg::CH_SPACE || char_i == kwl_pkg::CH_TAB) begin
          // blank
        end else if (kwl_pkg::is_alpha(char_i) || kwl_pkg::is_digit(char_i) ||
                     char_i == kwl_pkg::CH_EQ || char_i == kwl_pkg::CH_COLON ||
                     char_i == kwl_pkg::CH_LT || char_i == kwl_pkg::CH_GT) begin
          start_o    = line_i;
          len_o      = '0;
          alive_o    = '1;
          ovf_o      = 1'b0;
          base_len   = '0;
          base_alive = '1;
          base_word  = kwl_pkg::is_alpha(char_i);
          add_c      = kwl_pkg::is_alpha(char_i) || kwl_pkg::is_digit(char_i);
          priority if (kwl_pkg::is_alpha(char_i))    mode_o = kwl_pkg::MODE_WORD;
          else if (kwl_pkg::is_digit(char_i))        mode_o = kwl_pkg::MODE_NUM;
          else if (char_i == kwl_pkg::CH_EQ)         mode_o = kwl_pkg::MODE_EQ;
          else if (char_i == kwl_pkg::CH_COLON)      mode_o = kwl_pkg::MODE_COLON;
          else if (char_i == kwl_pkg::CH_LT)         mode_o = kwl_pkg::MODE_LT;
          else                                       mode_o = kwl_pkg::MODE_GT;
        end else begin
          single_vld = 1'b1;
          priority case (char_i)
            kwl_pkg::CH_SEMI:   single.code = kwl_pkg::TK_SEMI;
            kwl_pkg::CH_DOT:    single.code = kwl_pkg::TK_DOT;
            kwl_pkg::CH_PLUS:   single.code = kwl_pkg::TK_PLUS;
            kwl_pkg::CH_MINUS:  single.code = kwl_pkg::TK_MINUS;
            kwl_pkg::CH_STAR:   single.code = kwl_pkg::TK_STAR;
            kwl_pkg::CH_SLASH:  single.code = kwl_pkg::TK_SLASH;
            kwl_pkg::CH_COMMA:  single.code = kwl_pkg::TK_COMMA;
            kwl_pkg::CH_LPAREN: single.code = kwl_pkg::TK_LPAREN;
            kwl_pkg::CH_RPAREN: single.code = kwl_pkg::TK_RPAREN;
            default:            single.code = kwl_pkg::TK_ERR;
          endcase
        end
        if (single_vld) begin
          tok_o[n[0]] = single;
          n = n + 2'd1;
        end
      end

      if (add_c) begin
        if (base_word) begin
          for (int k = 0; k < kwl_pkg::KwCount; k++) begin
            if ((LenW + 4)'(base_len) >= (LenW + 4)'(kwl_pkg::KW_LEN[k])) begin
              base_alive[k] = 1'b0;
            end else if (kwl_pkg::KW_TEXT[k][base_len[2:0]] != char_i) begin
              base_alive[k] = 1'b0;
            end
          end
          alive_o = base_alive;
        end
        if (base_len < MaxLen) begin
          len_o = base_len + LenW'(1);
        end else begin
          ovf_o = 1'b1;
        end
      end
    end

    if (n == 2'd1) tok_o[0].last = 1'b1;
    if (n == 2'd2) tok_o[1].last = 1'b1;
    cnt_o = n;
  end

endmodule

`default_nettype wire

[sv/keyword_token_lexer.sv]
// keyword token lexer: streaming lexer for a small pascal-like language
//
// char_i takes one source character item per handshake (char_code, or end_of_input
// to mark the end of the text). token_o gives the tokens: code, starting line,
// length, an over-long flag and last_of_run on the final token of a character.
// A character item lands in an input register; the scan logic then turns it and
// the lexer state combinationally into zero, one or two tokens, written to a
// two-entry result register whose head drives token_o. A new character is taken
// every cycle while token_o takes each token and each character gives at most one
// token; a character that gives two tokens holds up the next one until its second
// token is taken, bound by the single token port.
// When token_o stalls, one character waits in the input register and char_i
// holds ready low until the result register frees up.
// Reset puts the line counter at one, drops any lexeme in progress and clears
// both registers. After the end token nothing more is produced until reset.
`default_nettype none

module keyword_token_lexer #(
  parameter int unsigned MaxLexeme = kwl_pkg::MaxLexemeDef,
  parameter int unsigned LineBits  = kwl_pkg::LineBitsDef
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  kwl_char_if.sink   char_i,
  kwl_token_if.source token_o
);

  localparam int unsigned LenW = $clog2(MaxLexeme + 1);

  // input register
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_end_q;

  // lexer state
  logic [2:0]                  mode_q, mode_d;
  logic [LineBits-1:0]         line_q, line_d;
  logic [LineBits-1:0]         start_q, start_d;
  logic [LenW-1:0]             len_q, len_d;
  logic [kwl_pkg::KwCount-1:0] alive_q, alive_d;
  logic                        ovf_q, ovf_d;
  logic                        fin_q, fin_d;

  // result register
  kwl_pkg::tok_t tok_q [2];
  kwl_pkg::tok_t tok_d [2];
  logic [1:0]    cnt_d;
  logic [1:0]    rem_q;
  logic          head_q;

  logic out_fire, res_free, process;

  assign out_fire = token_o.valid && token_o.ready;
  assign res_free = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_fire);
  assign process  = in_vld_q && res_free;
  assign char_i.ready = !in_vld_q || process;

  kwl_scan #(
    .MaxLexeme(MaxLexeme),
    .LineBits (LineBits)
  ) u_scan (
    .char_i (in_char_q),
    .end_i  (in_end_q),
    .mode_i (mode_q),
    .line_i (line_q),
    .start_i(start_q),
    .len_i  (len_q),
    .alive_i(alive_q),
    .ovf_i  (ovf_q),
    .fin_i  (fin_q),
    .mode_o (mode_d),
    .line_o (line_d),
    .start_o(start_d),
    .len_o  (len_d),
    .alive_o(alive_d),
    .ovf_o  (ovf_d),
    .fin_o  (fin_d),
    .tok_o  (tok_d),
    .cnt_o  (cnt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (char_i.ready) begin
      in_vld_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      in_char_q <= char_i.char_code;
      in_end_q  <= char_i.end_of_input;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= kwl_pkg::MODE_IDLE;
      line_q  <= LineBits'(1);
      start_q <= '0;
      len_q   <= '0;
      alive_q <= '1;
      ovf_q   <= 1'b0;
      fin_q   <= 1'b0;
    end else if (process) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      start_q <= start_d;
      len_q   <= len_d;
      alive_q <= alive_d;
      ovf_q   <= ovf_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      head_q <= 1'b0;
    end else if (process) begin
      rem_q  <= cnt_d;
      head_q <= 1'b0;
    end else if (out_fire) begin
      rem_q  <= rem_q - 2'd1;
      head_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      tok_q[0] <= tok_d[0];
      tok_q[1] <= tok_d[1];
    end
  end

  assign token_o.valid         = (rem_q != 2'd0);
  assign token_o.token_code    = tok_q[head_q].code;
  assign token_o.token_line    = tok_q[head_q].line;
  assign token_o.lexeme_length = tok_q[head_q].len;
  assign token_o.too_long      = tok_q[head_q].too_long;
  assign token_o.last_of_run   = tok_q[head_q].last;

endmodule

`default_nettype wire

[verif/tb_keyword_token_lexer.sv]
// self-checking testbench for the keyword token lexer: character stream in, predicted tokens out
`timescale 1ns / 1ps

module tb_keyword_token_lexer;

  localparam int unsigned MAX_LEX = kwl_pkg::MaxLexemeDef;

  typedef struct packed {
    logic [7:0] code;
    logic       eoi;
  } src_char_t;

  logic clk;
  logic rst_n;

  kwl_char_if  char_bus ();
  kwl_token_if tok_bus ();

  keyword_token_lexer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_bus),
    .token_o(tok_bus)
  );

  string kw_words [9] = '{"program", "const", "var", "Begin", "read", "while", "do",
                          "end", "write"};
  logic [7:0] single_ops [9] = '{kwl_pkg::CH_SEMI, kwl_pkg::CH_DOT, kwl_pkg::CH_PLUS,
                                 kwl_pkg::CH_MINUS, kwl_pkg::CH_STAR, kwl_pkg::CH_SLASH,
                                 kwl_pkg::CH_COMMA, kwl_pkg::CH_LPAREN, kwl_pkg::CH_RPAREN};
  logic [7:0] pair_heads [4] = '{kwl_pkg::CH_EQ, kwl_pkg::CH_COLON, kwl_pkg::CH_LT,
                                 kwl_pkg::CH_GT};

  src_char_t       pending_chars [$];
  kwl_pkg::tok_t   expected_tokens [$];
  kwl_pkg::tok_t   step_toks [$];
  src_char_t       next_src;
  kwl_pkg::tok_t   got_tok;
  kwl_pkg::tok_t   want_tok;
  int unsigned     total_items;
  int unsigned     chars_taken;
  int unsigned     fail_count;
  int unsigned     hold_left;
  bit              hold_done;
  bit              char_fired;

  // lexer state as predicted
  logic [15:0] line_no;
  logic [15:0] lex_line;
  logic [2:0]  lex_mode;
  logic [4:0]  lex_len;
  logic [8:0]  kw_live;
  logic        lex_over;
  logic        text_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[keyword_token_lexer] ERROR");
    $finish;
  end

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_num_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic void put_tok(input logic [4:0] code, input logic [15:0] line,
                                  input logic [4:0] len, input logic over);
    kwl_pkg::tok_t t;
    t.code     = code;
    t.line     = line;
    t.len      = len;
    t.too_long = over;
    t.last     = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void grow_lexeme(input logic [7:0] c);
    if (lex_mode == kwl_pkg::MODE_WORD) begin
      for (int k = 0; k < 9; k++) begin
        if ((lex_len >= kw_words[k].len()) || (kw_words[k][lex_len] != c)) kw_live[k] = 1'b0;
      end
    end
    if (lex_len < MAX_LEX) lex_len = lex_len + 5'd1;
    else lex_over = 1'b1;
  endfunction

  function automatic void open_lexeme(input logic [2:0] mode);
    lex_mode = mode;
    lex_line = line_no;
    lex_len  = '0;
    kw_live  = '1;
    lex_over = 1'b0;
  endfunction

  // emits whatever lexeme is in progress
  function automatic void close_lexeme();
    logic [4:0] code;
    case (lex_mode)
      kwl_pkg::MODE_WORD: begin
        code = kwl_pkg::TK_ID;
        for (int k = 0; k < 9; k++) begin
          if (kw_live[k] && (kw_words[k].len() == lex_len)) code = kwl_pkg::TK_ID + 5'(k + 1);
        end
        put_tok(code, lex_line, lex_len, lex_over);
      end
      kwl_pkg::MODE_NUM:   put_tok(kwl_pkg::TK_NUM, lex_line, lex_len, lex_over);
      kwl_pkg::MODE_EQ:    put_tok(kwl_pkg::TK_ASSIGN, lex_line, 5'd1, 1'b0);
      kwl_pkg::MODE_COLON: put_tok(kwl_pkg::TK_ERR, lex_line, 5'd1, 1'b0);
      kwl_pkg::MODE_LT:    put_tok(kwl_pkg::TK_LT, lex_line, 5'd1, 1'b0);
      kwl_pkg::MODE_GT:    put_tok(kwl_pkg::TK_GT, lex_line, 5'd1, 1'b0);
      default: ;
    endcase
    lex_mode = kwl_pkg::MODE_IDLE;
  endfunction

  function automatic void first_char(input logic [7:0] c);
    if ((c == kwl_pkg::CH_SPACE) || (c == kwl_pkg::CH_TAB) || (c == kwl_pkg::CH_LF)) begin
      if (c == kwl_pkg::CH_LF) line_no = line_no + 16'd1;
    end else if (is_letter(c)) begin
      open_lexeme(kwl_pkg::MODE_WORD);
      grow_lexeme(c);
    end else if (is_num_char(c)) begin
      open_lexeme(kwl_pkg::MODE_NUM);
      grow_lexeme(c);
    end else begin
      case (c)
        kwl_pkg::CH_EQ:     open_lexeme(kwl_pkg::MODE_EQ);
        kwl_pkg::CH_COLON:  open_lexeme(kwl_pkg::MODE_COLON);
        kwl_pkg::CH_LT:     open_lexeme(kwl_pkg::MODE_LT);
        kwl_pkg::CH_GT:     open_lexeme(kwl_pkg::MODE_GT);
        kwl_pkg::CH_SEMI:   put_tok(kwl_pkg::TK_SEMI, line_no, 5'd1, 1'b0);
        kwl_pkg::CH_DOT:    put_tok(kwl_pkg::TK_DOT, line_no, 5'd1, 1'b0);
        kwl_pkg::CH_PLUS:   put_tok(kwl_pkg::TK_PLUS, line_no, 5'd1, 1'b0);
        kwl_pkg::CH_MINUS:  put_tok(kwl_pkg::TK_MINUS, line_no, 5'd1, 1'b0);
        kwl_pkg::CH_STAR:   put_tok(kwl_pkg::TK_STAR, line_no, 5'd1, 1'b0);
        kwl_pkg::CH_SLASH:  put_tok(kwl_pkg::TK_SLASH, line_no, 5'd1, 1'b0);
        kwl_pkg::CH_COMMA:  put_tok(kwl_pkg::TK_COMMA, line_no, 5'd1, 1'b0);
        kwl_pkg::CH_LPAREN: put_tok(kwl_pkg::TK_LPAREN, line_no, 5'd1, 1'b0);
        kwl_pkg::CH_RPAREN: put_tok(kwl_pkg::TK_RPAREN, line_no, 5'd1, 1'b0);
        default:            put_tok(kwl_pkg::TK_ERR, line_no, 5'd1, 1'b0);
      endcase
    end
  endfunction

  // one accepted character item -> zero, one or two expected tokens
  function automatic void scan_char(input logic [7:0] c, input logic eoi);
    logic          taken;
    kwl_pkg::tok_t t;
    taken = 1'b0;
    step_toks.delete();
    if (!text_done) begin
      if (eoi) begin
        close_lexeme();
        put_tok(kwl_pkg::TK_END, line_no, 5'd0, 1'b0);
        text_done = 1'b1;
      end else begin
        case (lex_mode)
          kwl_pkg::MODE_WORD: begin
            if (is_letter(c) || is_num_char(c)) begin
              grow_lexeme(c);
              taken = 1'b1;
            end else close_lexeme();
          end
          kwl_pkg::MODE_NUM: begin
            if (is_num_char(c)) begin
              grow_lexeme(c);
              taken = 1'b1;
            end else close_lexeme();
          end
          kwl_pkg::MODE_EQ, kwl_pkg::MODE_COLON, kwl_pkg::MODE_LT, kwl_pkg::MODE_GT: begin
            if (c == kwl_pkg::CH_EQ) begin
              put_tok((lex_mode == kwl_pkg::MODE_EQ) ? kwl_pkg::TK_EQEQ :
                      (lex_mode == kwl_pkg::MODE_COLON) ? kwl_pkg::TK_ASSIGN :
                      (lex_mode == kwl_pkg::MODE_LT) ? kwl_pkg::TK_LE : kwl_pkg::TK_GE,
                      lex_line, 5'd2, 1'b0);
              lex_mode = kwl_pkg::MODE_IDLE;
              taken = 1'b1;
            end else close_lexeme();
          end
          default: lex_mode = kwl_pkg::MODE_IDLE;
        endcase
        if (!taken) first_char(c);
      end
    end
    for (int i = 0; i < step_toks.size(); i++) begin
      t = step_toks[i];
      t.last = (i == step_toks.size() - 1);
      expected_tokens.push_back(t);
    end
  endfunction

  task automatic push_byte(input logic [7:0] c);
    src_char_t s;
    s.code = c;
    s.eoi  = 1'b0;
    pending_chars.push_back(s);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    int unsigned n;
    n = $urandom_range(0, 51);
    return (n < 26) ? 8'("a" + n) : 8'("A" + n - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
  endfunction

  // mostly short lexemes, now and then around and past the saturation point
  function automatic int unsigned lex_size();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_LEX - 2, MAX_LEX + 6)
                                        : $urandom_range(1, 8);
  endfunction

  task automatic gen_token();
    int unsigned pick;
    int unsigned n;
    string w;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      push_text(kw_words[$urandom_range(0, 8)]);
    end else if (pick < 28) begin
      // near misses: prefix, extension, flipped case
      w = kw_words[$urandom_range(0, 8)];
      case ($urandom_range(0, 2))
        0: push_text(w.substr(0, $urandom_range(0, w.len() - 2)));
        1: begin
          push_text(w);
          push_byte(rand_alnum());
        end
        default: begin
          w[0] = w[0] ^ 8'h20;
          push_text(w);
        end
      endcase
    end else if (pick < 43) begin
      n = lex_size();
      push_byte(rand_letter());
      repeat (n - 1) push_byte(rand_alnum());
    end else if (pick < 55) begin
      n = lex_size();
      repeat (n) push_byte(rand_digit());
    end else if (pick < 75) begin
      push_byte(single_ops[$urandom_range(0, 8)]);
    end else if (pick < 87) begin
      push_byte(pair_heads[$urandom_range(0, 3)]);
      if ($urandom_range(0, 1)) push_byte(kwl_pkg::CH_EQ);
    end else if (pick < 93) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) push_byte(rand_digit());
      push_byte(rand_letter());
    end
  endtask

  task automatic gen_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r >= 10) begin
      repeat ($urandom_range(1, 2)) begin
        push_byte((r < 55) ? kwl_pkg::CH_SPACE : (r < 70) ? kwl_pkg::CH_TAB : kwl_pkg::CH_LF);
      end
    end
  endtask

  function automatic int unsigned idle_pct(input bit sender);
    if (chars_taken < 550) return sender ? 13 : 80;
    else if (chars_taken < 1100) return sender ? 80 : 13;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] act);
    if (want !== act) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, act);
      fail_count++;
    end
  endtask

  // character driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!char_bus.valid || char_fired) begin
        if ((pending_chars.size() > 0) && ($urandom_range(0, 99) >= idle_pct(1'b1))) begin
          next_src = pending_chars.pop_front();
          char_bus.valid        <= 1'b1;
          char_bus.char_code    <= next_src.code;
          char_bus.end_of_input <= next_src.eoi;
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
      char_fired = 1'b0;
    end
  end

  // token receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && (chars_taken >= 1150)) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        tok_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        tok_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
    end
  end

  // monitor: predict on each accepted character, check each accepted token
  always @(posedge clk) begin
    if (rst_n) begin
      if (tok_bus.valid && tok_bus.ready) begin
        got_tok.code     = tok_bus.token_code;
        got_tok.line     = tok_bus.token_line;
        got_tok.len      = tok_bus.lexeme_length;
        got_tok.too_long = tok_bus.too_long;
        got_tok.last     = tok_bus.last_of_run;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token, expected none actual code %0d line %0d", $time,
                   got_tok.code, got_tok.line);
          fail_count++;
        end else begin
          want_tok = expected_tokens.pop_front();
          check_field("token_code", 16'(want_tok.code), 16'(got_tok.code));
          check_field("token_line", want_tok.line, got_tok.line);
          check_field("lexeme_length", 16'(want_tok.len), 16'(got_tok.len));
          check_field("too_long", 16'(want_tok.too_long), 16'(got_tok.too_long));
          check_field("last_of_run", 16'(want_tok.last), 16'(got_tok.last));
        end
      end
      if (char_bus.valid && char_bus.ready) begin
        scan_char(char_bus.char_code, char_bus.end_of_input);
        chars_taken++;
        char_fired = 1'b1;
      end
    end
  end

  initial begin
    src_char_t s;
    rst_n                 = 1'b0;
    char_bus.valid        = 1'b0;
    char_bus.char_code    = '0;
    char_bus.end_of_input = 1'b0;
    tok_bus.ready         = 1'b0;
    line_no       = 16'd1;
    lex_line      = '0;
    lex_mode      = kwl_pkg::MODE_IDLE;
    lex_len       = '0;
    kw_live       = '1;
    lex_over      = 1'b0;
    text_done     = 1'b0;
    chars_taken   = 0;
    fail_count    = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    char_fired    = 1'b0;

    // digit then letter, lone colon, two-char operators, flush plus error in one item
    push_text("12ab:x:===<=<>=>");
    push_byte(8'h0D);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(kwl_pkg::CH_TAB);
    push_byte(kwl_pkg::CH_LF);

    while (pending_chars.size() < 1600) begin
      gen_token();
      gen_gap();
    end
    s.code = 8'($urandom_range(0, 255));
    s.eoi  = 1'b1;
    pending_chars.push_back(s);
    // items after the end token give nothing
    repeat (3) begin
      s.code = 8'($urandom_range(0, 255));
      s.eoi  = 1'($urandom_range(0, 1));
      pending_chars.push_back(s);
    end
    total_items = pending_chars.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (chars_taken != total_items) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[keyword_token_lexer] OK");
    end else begin
      $display("[keyword_token_lexer] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/kwl_pkg.sv
sv/kwl_char_if.sv
sv/kwl_token_if.sv
sv/kwl_scan.sv
sv/keyword_token_lexer.sv
verif/tb_keyword_token_lexer.sv
